// ----- rtl/bfop_pkg.sv -----
// Shared types, constants and helper functions of the bounded FIFO with overflow policy.
`default_nettype none
package bfop_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam int CMD_W   = 2;
	localparam int WORD_W  = 32;
	localparam int OCC_W   = 5;
	localparam int STAT_W  = 3;
	localparam int CFG_W   = 5;
	localparam int S_DATA_W = 32;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 72;
	localparam int M_USER_W = 4;
	localparam int M_PAD_W  = M_DATA_W - WORD_W - OCC_W - WORD_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_STOP = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE        = 3'd0,
		ST_FULL        = 3'd1,
		ST_NEW_DROPPED = 3'd2,
		ST_OLD_EVICTED = 3'd3,
		ST_EMPTY       = 3'd4,
		ST_STOPPED     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		POL_BLOCK    = 2'd0,
		POL_DROP_NEW = 2'd1,
		POL_DROP_OLD = 2'd2
	} policy_t;

	typedef enum logic {
		CFG_POLICY   = 1'b0,
		CFG_CAPACITY = 1'b1
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	typedef struct packed {
		logic               ok;
		logic               pop_ok;
		status_t            status;
		logic [CNT_W-1:0]   occupancy;
		logic [WORD_W-1:0]  drops;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [PTR_W-1:0]  raddr;
	} ram_req_t;

	// Clamp a programmed capacity into 1..DEPTH.
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CFG_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (int'(c) > DEPTH) begin
			r = CNT_W'(DEPTH);
		end else begin
			r = CNT_W'(c);
		end
		return r;
	endfunction

	// Step a ring pointer, wrapping at the active capacity.
	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] p1;
		p1 = CNT_W'(p) + CNT_W'(1);
		return (p1 >= cap) ? '0 : PTR_W'(p1);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/bfop_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module bfop_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic [$clog2(DEPTH)-1:0]        waddr,
	input  wire logic [WIDTH-1:0]                wdata,
	input  wire logic                            re,
	input  wire logic [$clog2(DEPTH)-1:0]        raddr,
	output logic      [WIDTH-1:0]                rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bfop_ctrl.sv -----
// Queue state, overflow policy and per-request result computation.
`default_nettype none
module bfop_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           acc,
	input  wire bfop_pkg::cmd_t                 cmd,
	input  wire logic [bfop_pkg::WORD_W-1:0]    push_data,
	input  wire logic                           cfg_we,
	input  wire bfop_pkg::cfg_idx_t             cfg_idx,
	input  wire logic [bfop_pkg::CFG_W-1:0]     cfg_data,
	output bfop_pkg::ram_req_t                  ram,
	output bfop_pkg::res_t                      res,
	output logic [bfop_pkg::CNT_W-1:0]          cap
);

	logic [bfop_pkg::PTR_W-1:0]  rd_ptr_q, wr_ptr_q, rd_ptr_n, wr_ptr_n;
	logic [bfop_pkg::CNT_W-1:0]  cnt_q, cnt_n, cap_q;
	logic [bfop_pkg::WORD_W-1:0] drops_q, drops_n;
	logic                        stopped_q, stopped_n;
	bfop_pkg::policy_t           pol_q;
	logic                        full, drop_inc;

	assign cap  = cap_q;
	assign full = (cnt_q == cap_q);

	always_comb begin
		rd_ptr_n   = rd_ptr_q;
		wr_ptr_n   = wr_ptr_q;
		cnt_n      = cnt_q;
		stopped_n  = stopped_q;
		drop_inc   = 1'b0;
		res.ok     = 1'b0;
		res.pop_ok = 1'b0;
		res.status = bfop_pkg::ST_DONE;
		ram.we     = 1'b0;
		ram.waddr  = wr_ptr_q;
		ram.wdata  = bfop_pkg::DATA_W'(push_data);
		ram.re     = 1'b0;
		ram.raddr  = rd_ptr_q;
		unique case (cmd)
			bfop_pkg::CMD_PUSH: begin
				if (stopped_q) begin
					res.status = bfop_pkg::ST_STOPPED;
				end else if (!full) begin
					ram.we   = acc;
					wr_ptr_n = bfop_pkg::adv(wr_ptr_q, cap_q);
					cnt_n    = cnt_q + bfop_pkg::CNT_W'(1);
					res.ok   = 1'b1;
				end else begin
					unique case (pol_q)
						bfop_pkg::POL_DROP_NEW: begin
							drop_inc   = 1'b1;
							res.status = bfop_pkg::ST_NEW_DROPPED;
						end
						bfop_pkg::POL_DROP_OLD: begin
							// evict the head and reuse its slot; count stays at capacity
							drop_inc   = 1'b1;
							rd_ptr_n   = bfop_pkg::adv(rd_ptr_q, cap_q);
							ram.we     = acc;
							wr_ptr_n   = bfop_pkg::adv(wr_ptr_q, cap_q);
							res.ok     = 1'b1;
							res.status = bfop_pkg::ST_OLD_EVICTED;
						end
						default: begin
							res.status = bfop_pkg::ST_FULL;
						end
					endcase
				end
			end
			bfop_pkg::CMD_POP: begin
				if (cnt_q != '0) begin
					ram.re     = acc;
					rd_ptr_n   = bfop_pkg::adv(rd_ptr_q, cap_q);
					cnt_n      = cnt_q - bfop_pkg::CNT_W'(1);
					res.ok     = 1'b1;
					res.pop_ok = 1'b1;
				end else begin
					res.status = stopped_q ? bfop_pkg::ST_STOPPED : bfop_pkg::ST_EMPTY;
				end
			end
			bfop_pkg::CMD_STOP: begin
				stopped_n = 1'b1;
			end
			default: begin
			end
		endcase
		drops_n = (drop_inc && drops_q != '1) ? drops_q + bfop_pkg::WORD_W'(1) : drops_q;
		res.occupancy = cnt_n;
		res.drops     = drops_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			cnt_q     <= '0;
			drops_q   <= '0;
			stopped_q <= 1'b0;
			pol_q     <= bfop_pkg::POL_BLOCK;
			cap_q     <= bfop_pkg::eff_cap(bfop_pkg::CAP_RESET);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bfop_pkg::CFG_POLICY: begin
					pol_q <= bfop_pkg::policy_t'(cfg_data[1:0]);
				end
				bfop_pkg::CFG_CAPACITY: begin
					cap_q    <= bfop_pkg::eff_cap(cfg_data);
					rd_ptr_q <= '0;
					wr_ptr_q <= '0;
					cnt_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			rd_ptr_q  <= rd_ptr_n;
			wr_ptr_q  <= wr_ptr_n;
			cnt_q     <= cnt_n;
			drops_q   <= drops_n;
			stopped_q <= stopped_n;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bounded_fifo_overflow_policy.sv -----
// Top level of the bounded FIFO with programmable capacity and overflow policy.
// Each request on the slave stream is a push, a pop or a stop command and
// yields exactly one result on the master stream. The block takes one request
// per clock: queue pointers, count and drop counter update at the accepting
// edge, and the result (with the popped word from the storage RAM's registered
// read port) is presented in the next cycle from a single result register. A new
// request is taken whenever that register is empty or is being drained in the
// same cycle, so throughput is one request per cycle.
// When full, policies 0 and 3 refuse the push, policy 1 drops the new word and
// policy 2 evicts the oldest; both drop policies count into a saturating 32-bit
// counter. A stop makes later pushes fail while pops keep draining. Writing
// the capacity register empties the queue. Storage needs no clearing pass
// after reset: entries are read only after being written. Write the
// configuration only while the block is idle.
`default_nettype none
module bounded_fifo_overflow_policy (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request stream
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [bfop_pkg::S_DATA_W-1:0]    s_tdata,  // [31:0] push_data
	input  wire logic [bfop_pkg::S_USER_W-1:0]    s_tuser,  // [1:0] cmd
	// result stream
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [31:0] pop_data, [36:32] occupancy, [68:37] drops, [71:69] zero
	output logic [bfop_pkg::M_DATA_W-1:0]         m_tdata,
	output logic [bfop_pkg::M_USER_W-1:0]         m_tuser,  // [0] ok, [3:1] status
	// configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_index,
	input  wire logic [bfop_pkg::CFG_W-1:0]       cfg_data
);

	logic                           acc;
	bfop_pkg::ram_req_t             ram;
	bfop_pkg::res_t                 res, res_s1;
	logic                           vld_s1;
	logic [bfop_pkg::DATA_W-1:0]    rdata;
	logic [bfop_pkg::CNT_W-1:0]     cap;
	logic [bfop_pkg::WORD_W-1:0]    pop_data;

	// Always take config; the user must send it only while the queue is idle, the block does not enforce it.
	assign cfg_ready = 1'b1;

	// Accept when the result register is free or drains this cycle.
	assign s_tready = !vld_s1 || m_tready;
	assign acc      = s_tvalid && s_tready;

	bfop_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.cmd       (bfop_pkg::cmd_t'(s_tuser[1:0])),
		.push_data (s_tdata[bfop_pkg::WORD_W-1:0]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (bfop_pkg::cfg_idx_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.ram       (ram),
		.res       (res),
		.cap       (cap)
	);

	// Storage: the read is issued at the accepting edge, so the word lines
	// up with the result register and holds while the output is stalled.
	bfop_ram #(
		.WIDTH (bfop_pkg::DATA_W),
		.DEPTH (bfop_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	// Result register: load on accept, hold while stalled, drop valid when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (m_tready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	// Zero the word unless this result is a successful pop.
	assign pop_data = res_s1.pop_ok ? bfop_pkg::WORD_W'(rdata) : '0;

	assign m_tvalid = vld_s1;
	assign m_tdata  = {{bfop_pkg::M_PAD_W{1'b0}}, res_s1.drops,
			bfop_pkg::OCC_W'(res_s1.occupancy), pop_data};
	assign m_tuser  = {res_s1.status, res_s1.ok};

	// Every accepted request leaves a result behind.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> vld_s1)
		else $error("accepted request produced no result");

	// A successful request reports done or eviction only.
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && res_s1.ok |->
			(res_s1.status == bfop_pkg::ST_DONE || res_s1.status == bfop_pkg::ST_OLD_EVICTED))
		else $error("ok result with failure status");

	// An empty report means nothing is held; a full report means something is.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (res_s1.status == bfop_pkg::ST_EMPTY || res_s1.status == bfop_pkg::ST_FULL)
			|-> (res_s1.status == bfop_pkg::ST_EMPTY) == (res_s1.occupancy == '0))
		else $error("empty/full status disagrees with occupancy");

	// Occupancy never exceeds the active capacity.
	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> res.occupancy <= cap)
		else $error("occupancy above capacity");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Stream testbench for the bounded FIFO with overflow policy: directed script, then random traffic.
`timescale 1ns / 100ps
module tb_top;
	import bfop_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 11;
	localparam int LIMIT_NS = 10_000_000;
	localparam int RANDOM_REQUESTS = 1340;

	// Codes the package leaves unnamed: the spare command and the spare policy.
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam logic [1:0] POL_UNUSED = 2'd3;

	// One result as seen on the master stream, split into its fields.
	typedef struct {
		logic               ok;
		logic [WORD_W-1:0]  word;
		logic [STAT_W-1:0]  status;
		logic [OCC_W-1:0]   occ;
		logic [WORD_W-1:0]  drops;
	} outcome_t;

	// One row of the directed script: either a register write or a request,
	// optionally with its result typed in by hand.
	typedef struct {
		bit                 is_cfg;
		cfg_idx_t           reg_sel;
		logic [CFG_W-1:0]   reg_val;
		logic [CMD_W-1:0]   cmd;
		logic [WORD_W-1:0]  word;
		bit                 typed;
		outcome_t           want;
	} script_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_DATA_W-1:0]    s_tdata = '0;
	logic [S_USER_W-1:0]    s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_DATA_W-1:0]    m_tdata;
	logic [M_USER_W-1:0]    m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_index = 1'b0;
	logic [CFG_W-1:0]       cfg_data = '0;

	bounded_fifo_overflow_policy dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Shadow copy of the ring: storage, pointers, count, drop counter, stop flag
	// and the two registers. Storage is only read where it was written.
	logic [DATA_W-1:0]  ring_mem [DEPTH];
	logic [PTR_W-1:0]   ring_rd = '0;
	logic [PTR_W-1:0]   ring_wr = '0;
	logic [CNT_W-1:0]   ring_cnt = '0;
	logic [WORD_W-1:0]  ring_drops = '0;
	bit                 ring_halted = 1'b0;
	logic [1:0]         ring_pol = POL_BLOCK;
	logic [CFG_W-1:0]   ring_cap = CAP_RESET;

	outcome_t      outcome_q[$];     // results owed by the block, oldest first
	script_row_t   script[$];        // directed rows waiting to be walked
	outcome_t      no_outcome;
	int            mismatch_count = 0;
	int            requests_sent = 0;
	int            sender_most = 0;  // longest gap before a request
	int            receiver_most = 0; // longest stall before taking a result
	bit            cfg_busy = 1'b0;

	// Active ring size: zero acts as one, anything past the storage as full depth.
	function automatic logic [CNT_W-1:0] ring_span();
		if (ring_cap == '0) return CNT_W'(1);
		if (int'(ring_cap) > DEPTH) return CNT_W'(DEPTH);
		return CNT_W'(ring_cap);
	endfunction

	function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p,
			logic [CNT_W-1:0] span);
		logic [CNT_W-1:0] q;
		q = CNT_W'(p) + CNT_W'(1);
		return (q >= span) ? '0 : PTR_W'(q);
	endfunction

	// Apply one request to the shadow ring and return the result it must produce.
	function automatic outcome_t ring_apply(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word);
		outcome_t o;
		logic [CNT_W-1:0] span;
		bit store;
		span = ring_span();
		o.ok = 1'b0;
		o.word = '0;
		o.status = ST_DONE;
		store = 1'b1;
		// Pull pointers and count back inside the active ring.
		if (CNT_W'(ring_rd) >= span) ring_rd = '0;
		if (CNT_W'(ring_wr) >= span) ring_wr = '0;
		if (ring_cnt > span) ring_cnt = span;
		case (cmd)
			CMD_PUSH: begin
				if (ring_halted) begin
					o.status = ST_STOPPED;
				end else begin
					if (ring_cnt == span) begin
						// Both drop policies lose a word; the counter saturates.
						if (ring_pol == POL_DROP_NEW || ring_pol == POL_DROP_OLD) begin
							if (ring_drops != '1) ring_drops = ring_drops + WORD_W'(1);
						end
						if (ring_pol == POL_DROP_NEW) begin
							o.status = ST_NEW_DROPPED;
							store = 1'b0;
						end else if (ring_pol == POL_DROP_OLD) begin
							ring_rd = ring_next(ring_rd, span);
							ring_cnt = ring_cnt - CNT_W'(1);
							o.status = ST_OLD_EVICTED;
						end else begin
							// Block and the spare policy both refuse.
							o.status = ST_FULL;
							store = 1'b0;
						end
					end
					if (store) begin
						ring_mem[ring_wr] = word;
						ring_wr = ring_next(ring_wr, span);
						ring_cnt = ring_cnt + CNT_W'(1);
						o.ok = 1'b1;
					end
				end
			end
			CMD_POP: begin
				// A stopped queue still drains what it holds.
				if (ring_cnt != '0) begin
					o.word = ring_mem[ring_rd];
					ring_rd = ring_next(ring_rd, span);
					ring_cnt = ring_cnt - CNT_W'(1);
					o.ok = 1'b1;
				end else begin
					o.status = ring_halted ? ST_STOPPED : ST_EMPTY;
				end
			end
			CMD_STOP: begin
				ring_halted = 1'b1;
			end
			default: begin
			end
		endcase
		o.occ = OCC_W'(ring_cnt);
		o.drops = ring_drops;
		return o;
	endfunction

	function automatic int pick_wait(int most);
		return (most == 0) ? 0 : $urandom_range(0, most);
	endfunction

	// Pace of one side: no idling, short gaps, or long gaps.
	function automatic int pick_pace();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 2;
			default: return 18;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Send one request after a random gap; hold valid high afterwards so a
	// back-to-back request needs no second assignment in the same step.
	task automatic send_req(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word, bit typed,
			outcome_t want);
		int gap;
		outcome_t got;
		gap = pick_wait(sender_most);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		got = ring_apply(cmd, word);
		outcome_q.push_back(typed ? want : got);
		requests_sent++;
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write one register; valid stays high so writes can follow back to back.
	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_POLICY) begin
			ring_pol = val[1:0];
		end else begin
			// A capacity write empties the queue but keeps drops and the stop flag.
			ring_cap = val;
			ring_rd = '0;
			ring_wr = '0;
			ring_cnt = '0;
		end
	endtask

	// Reprogram both registers at random, extremes included, and pick new paces.
	task automatic set_random_regs();
		logic [CFG_W-1:0] cap;
		case ($urandom_range(0, 9))
			0: cap = 5'd0;
			1: cap = 5'd1;
			2: cap = 5'd16;
			3: cap = 5'd31;
			4: cap = CFG_W'($urandom_range(17, 30));
			default: cap = CFG_W'($urandom_range(2, 6));
		endcase
		quiesce();
		write_reg(CFG_POLICY, CFG_W'($urandom_range(0, 3)));
		write_reg(CFG_CAPACITY, cap);
		cfg_valid <= 1'b0;
		sender_most = pick_pace();
		receiver_most = pick_pace();
	endtask

	task automatic add_cfg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		script_row_t r;
		r.is_cfg = 1'b1;
		r.reg_sel = idx;
		r.reg_val = val;
		r.cmd = CMD_NOP;
		r.word = '0;
		r.typed = 1'b0;
		r.want = no_outcome;
		script.push_back(r);
	endtask

	task automatic add_req(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word);
		script_row_t r;
		r.is_cfg = 1'b0;
		r.reg_sel = CFG_POLICY;
		r.reg_val = '0;
		r.cmd = cmd;
		r.word = word;
		r.typed = 1'b0;
		r.want = no_outcome;
		script.push_back(r);
	endtask

	// Request whose result is typed in: ok, popped word, status, occupancy, drops.
	task automatic add_checked(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word, logic ok,
			logic [WORD_W-1:0] popped, logic [STAT_W-1:0] st, logic [OCC_W-1:0] occ,
			logic [WORD_W-1:0] drops);
		add_req(cmd, word);
		script[$].typed = 1'b1;
		script[$].want.ok = ok;
		script[$].want.word = popped;
		script[$].want.status = st;
		script[$].want.occ = occ;
		script[$].want.drops = drops;
	endtask

	// Walk the script: drain before the first of a run of register writes,
	// lower the write valid before the next request.
	task automatic walk_script();
		script_row_t r;
		while (script.size() != 0) begin
			r = script.pop_front();
			if (r.is_cfg) begin
				if (!cfg_busy) quiesce();
				write_reg(r.reg_sel, r.reg_val);
				cfg_busy = 1'b1;
			end else begin
				if (cfg_busy) begin
					cfg_valid <= 1'b0;
					cfg_busy = 1'b0;
				end
				send_req(r.cmd, r.word, r.typed, r.want);
			end
		end
		if (cfg_busy) begin
			cfg_valid <= 1'b0;
			cfg_busy = 1'b0;
		end
	endtask

	// Random traffic in bursts that lean toward filling or draining, so the
	// ring keeps hitting full and empty. Spare commands do not count.
	task automatic run_phase(int items, bit with_stop);
		int left;
		int burst;
		int push_pct;
		int roll;
		logic [CMD_W-1:0] cmd;
		left = items;
		while (left > 0) begin
			burst = $urandom_range(1, 2 * int'(ring_span()) + 2);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			repeat (burst) begin
				if (left == 0) break;
				roll = $urandom_range(0, 99);
				if (roll < 3) cmd = CMD_NOP;
				else if (with_stop && roll < 6) cmd = CMD_STOP;
				else if (roll < push_pct + 3) cmd = CMD_PUSH;
				else cmd = CMD_POP;
				send_req(cmd, rand_word(), 1'b0, no_outcome);
				if (cmd != CMD_NOP) left--;
			end
		end
	endtask

	task automatic check_field(string label, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h, actual %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	// Result side: stall a random number of cycles before each result, then
	// compare it field by field with the oldest owed result.
	initial begin : result_side
		int gap;
		outcome_t want;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_wait(receiver_most);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (outcome_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual tdata %h tuser %h",
					$time, m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				want = outcome_q.pop_front();
				check_field("ok", WORD_W'(want.ok), WORD_W'(m_tuser[0]));
				check_field("pop_data", want.word, m_tdata[31:0]);
				check_field("status", WORD_W'(want.status), WORD_W'(m_tuser[3:1]));
				check_field("occupancy", WORD_W'(want.occ), WORD_W'(m_tdata[36:32]));
				check_field("drops", want.drops, m_tdata[68:37]);
			end
		end
	end

	// Request side and the overall sequence.
	initial begin : request_side
		no_outcome.ok = 1'b0;
		no_outcome.word = '0;
		no_outcome.status = ST_DONE;
		no_outcome.occ = '0;
		no_outcome.drops = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_most = pick_pace();
		receiver_most = pick_pace();

		// Opening script, from reset: policy block, capacity 16.
		add_checked(CMD_POP, 32'h0000_0000, 1'b0, '0, ST_EMPTY, 5'd0, '0);
		add_checked(CMD_NOP, 32'hFFFF_FFFF, 1'b0, '0, ST_DONE, 5'd0, '0);
		add_checked(CMD_PUSH, 32'h0000_0000, 1'b1, '0, ST_DONE, 5'd1, '0);
		add_checked(CMD_PUSH, 32'hFFFF_FFFF, 1'b1, '0, ST_DONE, 5'd2, '0);
		add_checked(CMD_POP, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE, 5'd1, '0);
		add_checked(CMD_POP, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_DONE, 5'd0, '0);
		// Single-entry ring: full on the second push, under each policy.
		add_cfg(CFG_CAPACITY, 5'd1);
		add_checked(CMD_PUSH, 32'h1234_5678, 1'b1, '0, ST_DONE, 5'd1, '0);
		add_checked(CMD_PUSH, 32'h0000_0009, 1'b0, '0, ST_FULL, 5'd1, '0);
		add_cfg(CFG_POLICY, CFG_W'(POL_DROP_NEW));
		add_checked(CMD_PUSH, 32'hDEAD_BEEF, 1'b0, '0, ST_NEW_DROPPED, 5'd1, 32'd1);
		add_cfg(CFG_POLICY, CFG_W'(POL_DROP_OLD));
		add_checked(CMD_PUSH, 32'h0BAD_F00D, 1'b1, '0, ST_OLD_EVICTED, 5'd1, 32'd2);
		add_checked(CMD_POP, 32'h0000_0000, 1'b1, 32'h0BAD_F00D, ST_DONE, 5'd0, 32'd2);
		// Spare policy refuses like block; capacity zero acts as one.
		add_cfg(CFG_POLICY, CFG_W'(POL_UNUSED));
		add_cfg(CFG_CAPACITY, 5'd0);
		add_checked(CMD_PUSH, 32'h5555_5555, 1'b1, '0, ST_DONE, 5'd1, 32'd2);
		add_checked(CMD_PUSH, 32'hAAAA_AAAA, 1'b0, '0, ST_FULL, 5'd1, 32'd2);
		// Capacity past the storage depth acts as full depth.
		add_cfg(CFG_CAPACITY, 5'd17);
		add_cfg(CFG_POLICY, CFG_W'(POL_DROP_NEW));
		add_req(CMD_PUSH, 32'h1357_9BDF);
		add_req(CMD_PUSH, 32'h8000_0001);
		add_req(CMD_POP, 32'h7FFF_FFFE);
		add_req(CMD_POP, 32'h0000_0000);
		walk_script();

		// Random phases; every phase starts from a drained queue with new settings.
		while (requests_sent < RANDOM_REQUESTS) begin
			set_random_regs();
			run_phase($urandom_range(40, 120), 1'b0);
		end

		// Closing script: stop is sticky, so it only comes at the end.
		add_cfg(CFG_CAPACITY, 5'd4);
		add_req(CMD_PUSH, 32'h1111_1111);
		add_req(CMD_PUSH, 32'hEEEE_EEEE);
		add_req(CMD_STOP, 32'h0000_0000);
		add_req(CMD_PUSH, 32'h2222_2222);
		add_req(CMD_POP, 32'h0000_0000);
		add_req(CMD_POP, 32'h0000_0000);
		add_req(CMD_POP, 32'h0000_0000);
		add_req(CMD_STOP, 32'hFFFF_FFFF);
		walk_script();

		// Stopped tail: pushes fail, pops report stopped, capacity write keeps the flag.
		set_random_regs();
		run_phase(50, 1'b1);

		// Drain, then wait for any stray result.
		quiesce();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#(LIMIT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
